// File: rtl/sfc_pkg.sv
// Shared types, codes and the CRC-8 byte step for the SPI register frame block.
`default_nettype none
package sfc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DataW  = 24;
  localparam int unsigned NBytes = 4;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CHECK = 2'd2;

  localparam logic [1:0] CFG_CRC_ENABLED = 2'd0;
  localparam logic [1:0] CFG_CRC_POLY    = 2'd1;
  localparam logic [1:0] CFG_CRC_INIT    = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR  = 2'd1;
  localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

  localparam logic [ByteW-1:0] ADDR_READ_BIT  = 8'h80;
  localparam logic [ByteW-1:0] ADDR_MASK      = 8'h7F;
  localparam logic [ByteW-1:0] FILL_BYTE      = 8'hFF;
  localparam logic [ByteW-1:0] BAD_WRITE_ADDR = 8'hFF;

  localparam logic [2:0] LEN_SHORT = 3'd4;
  localparam logic [2:0] LEN_CRC   = 3'd5;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_WRITE,
    KIND_READ,
    KIND_CHECK,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    kind_t                          kind;
    logic [NBytes-1:0][ByteW-1:0]   bytes;
    logic [ByteW-1:0]               rx_crc;
    logic [ByteW-1:0]               crc;
  } pipe_t;

  // One byte of an MSB-first CRC-8.
  function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] data,
                                                 input logic [ByteW-1:0] poly);
    logic [ByteW-1:0] c;
    c = crc ^ data;
    for (int b = 0; b < ByteW; b++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/sfc_crc_stage.sv
// One pipeline stage that folds one frame byte into the running CRC-8.
`default_nettype none
module sfc_crc_stage
  import sfc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire pipe_t            in_pipe,
  input  wire logic [ByteW-1:0] data_byte,
  input  wire logic [ByteW-1:0] crc_poly,
  output logic                  out_valid,
  output pipe_t                 out_pipe
);

  pipe_t pipe_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_comb begin
    pipe_next     = in_pipe;
    pipe_next.crc = crc8_byte(in_pipe.crc, data_byte, crc_poly);
  end

  always_ff @(posedge clk) begin
    out_pipe <= pipe_next;
  end

endmodule
`default_nettype wire

// File: rtl/spi_register_frame_crc8.sv
// Top level of the SPI register frame builder and response checker with CRC-8.
`default_nettype none
// Takes one transaction per clock cycle while busy is low: a write frame, a
// read frame or a response check. The result appears on the output ports with
// done high for one cycle and cannot be stalled by the receiver. It passes
// through an input register, four CRC stages that each fold one frame byte
// into the CRC-8, and the output register.
// busy is high only while rst is asserted. Configuration writes through wr_en
// take effect at once and should be made while no transaction is in flight.
module spi_register_frame_crc8
  import sfc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       mode,
  input  wire logic [ByteW-1:0] address,
  input  wire logic [DataW-1:0] write_data,
  input  wire logic [ByteW-1:0] rx_first,
  input  wire logic [ByteW-1:0] rx_second,
  input  wire logic [ByteW-1:0] rx_third,
  input  wire logic [ByteW-1:0] rx_fourth,
  input  wire logic [ByteW-1:0] rx_fifth,
  input  wire logic             wr_en,
  input  wire logic [1:0]       wr_index,
  input  wire logic [ByteW-1:0] wr_data,
  output logic                  done,
  output logic [ByteW-1:0]      frame_first,
  output logic [ByteW-1:0]      frame_second,
  output logic [ByteW-1:0]      frame_third,
  output logic [ByteW-1:0]      frame_fourth,
  output logic [ByteW-1:0]      frame_fifth,
  output logic [2:0]            frame_len,
  output logic [DataW-1:0]      read_data,
  output logic [1:0]            status
);

  logic             crc_enabled;
  logic [ByteW-1:0] crc_poly;
  logic [ByteW-1:0] crc_init;

  logic             accept;
  pipe_t            entry;
  logic  [NBytes:0] stage_valid;
  pipe_t            stage_pipe [NBytes+1];

  logic [ByteW-1:0] frame_first_next;
  logic [ByteW-1:0] frame_second_next;
  logic [ByteW-1:0] frame_third_next;
  logic [ByteW-1:0] frame_fourth_next;
  logic [ByteW-1:0] frame_fifth_next;
  logic [2:0]       frame_len_next;
  logic [DataW-1:0] read_data_next;
  logic [1:0]       status_next;

  assign busy   = rst;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_enabled <= 1'b1;
      crc_poly    <= 8'h07;
      crc_init    <= 8'h00;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_CRC_ENABLED: crc_enabled <= wr_data[0];
        CFG_CRC_POLY:    crc_poly    <= wr_data;
        CFG_CRC_INIT:    crc_init    <= wr_data;
        default:         ;
      endcase
    end
  end

  // Sort the transaction and lay out the four bytes that the CRC covers.
  always_comb begin
    entry        = '0;
    entry.rx_crc = rx_fifth;
    entry.crc    = crc_init;
    unique case (mode)
      MODE_WRITE: begin
        if (address == BAD_WRITE_ADDR) begin
          entry.kind = KIND_BAD;
        end else begin
          entry.kind     = KIND_WRITE;
          entry.bytes[0] = address & ADDR_MASK;
          entry.bytes[1] = write_data[7:0];
          entry.bytes[2] = write_data[15:8];
          entry.bytes[3] = write_data[23:16];
        end
      end
      MODE_READ: begin
        entry.kind     = KIND_READ;
        entry.bytes[0] = address | ADDR_READ_BIT;
        entry.bytes[1] = FILL_BYTE;
        entry.bytes[2] = FILL_BYTE;
        entry.bytes[3] = FILL_BYTE;
      end
      MODE_CHECK: begin
        entry.kind     = KIND_CHECK;
        entry.bytes[0] = rx_first;
        entry.bytes[1] = rx_second;
        entry.bytes[2] = rx_third;
        entry.bytes[3] = rx_fourth;
      end
      default: entry.kind = KIND_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid[0] <= 1'b0;
    end else begin
      stage_valid[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    stage_pipe[0] <= entry;
  end

  for (genvar k = 0; k < NBytes; k++) begin : g_crc
    sfc_crc_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[k]),
      .in_pipe   (stage_pipe[k]),
      .data_byte (stage_pipe[k].bytes[k]),
      .crc_poly  (crc_poly),
      .out_valid (stage_valid[k+1]),
      .out_pipe  (stage_pipe[k+1])
    );
  end

  pipe_t last;
  assign last = stage_pipe[NBytes];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_valid[NBytes];
    end
  end

  always_comb begin
    frame_first_next  = '0;
    frame_second_next = '0;
    frame_third_next  = '0;
    frame_fourth_next = '0;
    frame_fifth_next  = '0;
    frame_len_next    = '0;
    read_data_next    = '0;
    status_next       = STATUS_OK;
    unique case (last.kind)
      KIND_WRITE, KIND_READ: begin
        frame_first_next  = last.bytes[0];
        frame_second_next = last.bytes[1];
        frame_third_next  = last.bytes[2];
        frame_fourth_next = last.bytes[3];
        frame_fifth_next  = crc_enabled ? last.crc : '0;
        frame_len_next    = crc_enabled ? LEN_CRC : LEN_SHORT;
      end
      KIND_CHECK: begin
        if (crc_enabled && (last.crc != last.rx_crc)) begin
          status_next = STATUS_CRC_ERR;
        end else begin
          read_data_next = {last.bytes[3], last.bytes[2], last.bytes[1]};
        end
      end
      KIND_BAD:  status_next = STATUS_BAD_ADDR;
      KIND_NONE: ;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    frame_first  <= frame_first_next;
    frame_second <= frame_second_next;
    frame_third  <= frame_third_next;
    frame_fourth <= frame_fourth_next;
    frame_fifth  <= frame_fifth_next;
    frame_len    <= frame_len_next;
    read_data    <= read_data_next;
    status       <= status_next;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 6))
    else $error("result strobe without a transfer six cycles earlier");

  a_crc_err_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_CRC_ERR) |-> (read_data == '0 && frame_len == '0))
    else $error("CRC mismatch result carries data");

  a_len_needs_crc: assert property (@(posedge clk) disable iff (rst)
    (done && frame_len == LEN_CRC) |-> crc_enabled)
    else $error("five-byte frame built with CRC disabled");
`endif

endmodule
`default_nettype wire

// File: test/tb_spi_register_frame_crc8.sv
// Testbench for the SPI register frame builder and response checker with CRC-8.
`timescale 1ns / 100ps

module tb_spi_register_frame_crc8;
  import sfc_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 12;
  localparam int unsigned PHASE_ITEMS = 215;

  typedef struct packed {
    logic [1:0]            mode;
    logic [ByteW-1:0]      address;
    logic [DataW-1:0]      write_data;
    logic [4:0][ByteW-1:0] rx;
  } frame_req_t;

  typedef struct packed {
    logic [4:0][ByteW-1:0] frame;
    logic [2:0]            len;
    logic [DataW-1:0]      read_data;
    logic [1:0]            status;
  } frame_rsp_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       mode = '0;
  logic [ByteW-1:0] address = '0;
  logic [DataW-1:0] write_data = '0;
  logic [ByteW-1:0] rx_first = '0;
  logic [ByteW-1:0] rx_second = '0;
  logic [ByteW-1:0] rx_third = '0;
  logic [ByteW-1:0] rx_fourth = '0;
  logic [ByteW-1:0] rx_fifth = '0;
  logic             wr_en = 1'b0;
  logic [1:0]       wr_index = '0;
  logic [ByteW-1:0] wr_data = '0;
  logic             done;
  logic [ByteW-1:0] frame_first;
  logic [ByteW-1:0] frame_second;
  logic [ByteW-1:0] frame_third;
  logic [ByteW-1:0] frame_fourth;
  logic [ByteW-1:0] frame_fifth;
  logic [2:0]       frame_len;
  logic [DataW-1:0] read_data;
  logic [1:0]       status;

  // Local copy of the configuration registers.
  logic             cfg_crc_on = 1'b1;
  logic [ByteW-1:0] cfg_poly = 8'h07;
  logic [ByteW-1:0] cfg_init = 8'h00;

  frame_rsp_t  frames_due[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;

  spi_register_frame_crc8 u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .address      (address),
    .write_data   (write_data),
    .rx_first     (rx_first),
    .rx_second    (rx_second),
    .rx_third     (rx_third),
    .rx_fourth    (rx_fourth),
    .rx_fifth     (rx_fifth),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .done         (done),
    .frame_first  (frame_first),
    .frame_second (frame_second),
    .frame_third  (frame_third),
    .frame_fourth (frame_fourth),
    .frame_fifth  (frame_fifth),
    .frame_len    (frame_len),
    .read_data    (read_data),
    .status       (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Bitwise MSB-first CRC-8 over the four frame bytes, byte 0 first.
  function automatic logic [ByteW-1:0] frame_crc8(input logic [3:0][ByteW-1:0] body);
    logic [ByteW-1:0] c;
    logic             fb;
    c = cfg_init;
    for (int i = 0; i < 4; i++) begin
      for (int k = ByteW - 1; k >= 0; k--) begin
        fb = c[ByteW-1] ^ body[i][k];
        c = {c[ByteW-2:0], 1'b0} ^ (fb ? cfg_poly : 8'h00);
      end
    end
    return c;
  endfunction

  function automatic frame_rsp_t build_frame(input frame_req_t req);
    frame_rsp_t            rsp;
    logic [3:0][ByteW-1:0] body;
    rsp = '0;
    body = '0;
    case (req.mode)
      MODE_WRITE, MODE_READ: begin
        if (req.mode == MODE_WRITE && req.address == BAD_WRITE_ADDR) begin
          rsp.status = STATUS_BAD_ADDR;
        end else begin
          if (req.mode == MODE_WRITE) begin
            body = {req.write_data, req.address & ADDR_MASK};
          end else begin
            body = {FILL_BYTE, FILL_BYTE, FILL_BYTE, req.address | ADDR_READ_BIT};
          end
          rsp.frame = {8'h00, body};
          rsp.len = LEN_SHORT;
          if (cfg_crc_on) begin
            rsp.frame[4] = frame_crc8(body);
            rsp.len = LEN_CRC;
          end
          rsp.status = STATUS_OK;
        end
      end
      MODE_CHECK: begin
        if (cfg_crc_on && frame_crc8(req.rx[3:0]) != req.rx[4]) begin
          rsp.status = STATUS_CRC_ERR;
        end else begin
          rsp.read_data = {req.rx[3], req.rx[2], req.rx[1]};
          rsp.status = STATUS_OK;
        end
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  function automatic frame_req_t make_req(input logic [1:0] m, input logic [ByteW-1:0] a,
                                          input logic [DataW-1:0] wd);
    frame_req_t r;
    r.mode = m;
    r.address = a;
    r.write_data = wd;
    r.rx[3:0] = $urandom();
    r.rx[4] = ByteW'($urandom_range(255));
    return r;
  endfunction

  // A response whose CRC byte matches the current settings.
  function automatic frame_req_t good_response(input logic [3:0][ByteW-1:0] body);
    frame_req_t r;
    r = make_req(MODE_CHECK, ByteW'($urandom_range(255)),
                 DataW'($urandom_range(24'hFFFFFF)));
    r.rx = {frame_crc8(body), body};
    return r;
  endfunction

  function automatic frame_req_t random_req();
    frame_req_t  r;
    int unsigned pick;
    int unsigned addr_pick;
    pick = $urandom_range(99);
    addr_pick = $urandom_range(19);
    r = make_req(MODE_WRITE, ByteW'($urandom_range(255)),
                 DataW'($urandom_range(24'hFFFFFF)));
    case (addr_pick)
      0: r.address = BAD_WRITE_ADDR;
      1: r.address = 8'h7F;
      2: r.address = 8'h80;
      3: r.address = 8'h00;
      default: begin
      end
    endcase
    if (pick < 30) begin
      r.mode = MODE_WRITE;
    end else if (pick < 55) begin
      r.mode = MODE_READ;
    end else if (pick < 95) begin
      r.mode = MODE_CHECK;
      // Most responses are well formed so that the data path is exercised.
      if ($urandom_range(99) < 70) begin
        r.rx[4] = frame_crc8(r.rx[3:0]);
      end
    end else begin
      r.mode = MODE_UNUSED;
    end
    return r;
  endfunction

  task automatic send_item(input frame_req_t req);
    start      <= 1'b1;
    mode       <= req.mode;
    address    <= req.address;
    write_data <= req.write_data;
    rx_first   <= req.rx[0];
    rx_second  <= req.rx[1];
    rx_third   <= req.rx[2];
    rx_fourth  <= req.rx[3];
    rx_fifth   <= req.rx[4];
    do @(posedge clk); while (busy);
    frames_due.push_back(build_frame(req));
  endtask

  task automatic idle_for(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_frames();
    start <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [ByteW-1:0] value);
    wr_en    <= 1'b1;
    wr_index <= index;
    wr_data  <= value;
    @(posedge clk);
    wr_en <= 1'b0;
    case (index)
      CFG_CRC_ENABLED: cfg_crc_on = value[0];
      CFG_CRC_POLY:    cfg_poly = value;
      CFG_CRC_INIT:    cfg_init = value;
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic check_field(input string what, input logic [DataW-1:0] want,
                             input logic [DataW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_frames
    frame_rsp_t want;
    if (!rst && done) begin
      if (frames_due.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual frame %0h",
                 $time, {frame_fifth, frame_fourth, frame_third, frame_second, frame_first});
        mismatch_count++;
      end else begin
        want = frames_due.pop_front();
        check_field("frame_first", DataW'(want.frame[0]), DataW'(frame_first));
        check_field("frame_second", DataW'(want.frame[1]), DataW'(frame_second));
        check_field("frame_third", DataW'(want.frame[2]), DataW'(frame_third));
        check_field("frame_fourth", DataW'(want.frame[3]), DataW'(frame_fourth));
        check_field("frame_fifth", DataW'(want.frame[4]), DataW'(frame_fifth));
        check_field("frame_len", DataW'(want.len), DataW'(frame_len));
        check_field("read_data", want.read_data, read_data);
        check_field("status", DataW'(want.status), DataW'(status));
      end
    end
  end

  // Reset settings: CRC on, polynomial 0x07, initial value 0.
  task automatic test_default_frames();
    frame_req_t r;
    send_item(make_req(MODE_WRITE, 8'h00, 24'h000000));
    send_item(make_req(MODE_WRITE, 8'h7F, 24'hFFFFFF));
    send_item(make_req(MODE_WRITE, 8'h80, 24'h123456));
    send_item(make_req(MODE_WRITE, 8'hFE, 24'hA5A5A5));
    send_item(make_req(MODE_WRITE, BAD_WRITE_ADDR, 24'hFFFFFF));
    send_item(make_req(MODE_READ, 8'h00, DataW'($urandom_range(24'hFFFFFF))));
    send_item(make_req(MODE_READ, 8'hFF, DataW'($urandom_range(24'hFFFFFF))));
    send_item(make_req(MODE_READ, 8'h7F, DataW'($urandom_range(24'hFFFFFF))));
    send_item(good_response(32'h00000000));
    send_item(good_response(32'hFFFFFFFF));
    send_item(good_response($urandom()));
    r = good_response($urandom());
    r.rx[4] = ~r.rx[4];
    send_item(r);
    send_item(make_req(MODE_UNUSED, ByteW'($urandom_range(255)),
                       DataW'($urandom_range(24'hFFFFFF))));
    wait_for_frames();
  endtask

  // Four-byte frames, and a response with a wrong CRC byte that must pass.
  task automatic test_crc_disabled();
    frame_req_t r;
    write_reg(CFG_CRC_ENABLED, {7'($urandom_range(127)), 1'b0});
    write_reg(CFG_UNUSED, ByteW'($urandom_range(255)));
    send_item(make_req(MODE_WRITE, 8'h12, 24'h00FF00));
    send_item(make_req(MODE_READ, 8'h34, 24'h000000));
    send_item(make_req(MODE_WRITE, BAD_WRITE_ADDR, 24'h000000));
    r = good_response($urandom());
    r.rx[4] = r.rx[4] ^ 8'h5A;
    send_item(r);
    send_item(make_req(MODE_UNUSED, ByteW'($urandom_range(255)),
                       DataW'($urandom_range(24'hFFFFFF))));
    wait_for_frames();
    write_reg(CFG_CRC_ENABLED, {7'($urandom_range(127)), 1'b1});
  endtask

  task automatic test_extreme_crc_settings();
    frame_req_t r;
    write_reg(CFG_CRC_POLY, 8'hFF);
    write_reg(CFG_CRC_INIT, 8'hFF);
    send_item(make_req(MODE_WRITE, 8'h55, 24'hFFFFFF));
    send_item(make_req(MODE_READ, 8'hAA, 24'h000000));
    send_item(good_response($urandom()));
    wait_for_frames();
    write_reg(CFG_CRC_POLY, 8'h00);
    write_reg(CFG_CRC_INIT, 8'h00);
    send_item(make_req(MODE_WRITE, 8'h01, 24'h800001));
    send_item(good_response($urandom()));
    r = good_response($urandom());
    r.rx[4] = r.rx[4] ^ 8'h80;
    send_item(r);
    wait_for_frames();
  endtask

  // Six phases with their own settings; the sender idles often, then more, then never.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_CRC_ENABLED, 8'h01);
          write_reg(CFG_CRC_POLY, 8'h07);
          write_reg(CFG_CRC_INIT, 8'h00);
        end
        1: begin
          write_reg(CFG_CRC_ENABLED, 8'h00);
          write_reg(CFG_CRC_POLY, ByteW'($urandom_range(255)));
        end
        2: begin
          write_reg(CFG_CRC_ENABLED, 8'h01);
          write_reg(CFG_CRC_POLY, 8'hFF);
          write_reg(CFG_CRC_INIT, 8'hFF);
        end
        4: begin
          write_reg(CFG_CRC_POLY, 8'h00);
          write_reg(CFG_CRC_INIT, 8'h00);
        end
        default: begin
          write_reg(CFG_CRC_ENABLED, ByteW'($urandom_range(255)) | 8'h01);
          write_reg(CFG_CRC_POLY, ByteW'($urandom_range(255)));
          write_reg(CFG_CRC_INIT, ByteW'($urandom_range(255)));
        end
      endcase
      idle_pct = (phase < 2) ? 14 : (phase < 4) ? 54 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_req());
        // Each cycle is left idle with the phase's chance.
        while ($urandom_range(99) < idle_pct) begin
          idle_for(1);
        end
      end
      // Hold off until every transfer of the phase has come back.
      wait_for_frames();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_frames();
    test_crc_disabled();
    test_extreme_crc_settings();
    test_random_traffic();
    wait_for_frames();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: spi_register_frame_crc8.f
rtl/sfc_pkg.sv
rtl/sfc_crc_stage.sv
rtl/spi_register_frame_crc8.sv
test/tb_spi_register_frame_crc8.sv
